// ===== src/lcs_line_diff_unit_assert.svh =====
`ifndef LCS_LINE_DIFF_UNIT_ASSERT_SVH
`define LCS_LINE_DIFF_UNIT_ASSERT_SVH
// implication checked every cycle outside reset
`define LCD_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lcd check");
// next-cycle implication
`define LCD_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lcd check");
`endif

// ===== src/lcd_pkg.sv =====
package lcd_pkg;
  localparam int MaxLinesDef = 32;
  localparam int RowCap = 64;

  localparam logic [2:0] OP_APPEND_A = 3'd0;
  localparam logic [2:0] OP_APPEND_B = 3'd1;
  localparam logic [2:0] OP_CLEAR_A  = 3'd2;
  localparam logic [2:0] OP_CLEAR_B  = 3'd3;
  localparam logic [2:0] OP_COMPARE  = 3'd4;

  localparam logic [1:0] KIND_SAME  = 2'd0;
  localparam logic [1:0] KIND_AONLY = 2'd1;
  localparam logic [1:0] KIND_BONLY = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic CFG_ROW_LIMIT = 1'b0;
  localparam logic CFG_FORCE_RAW = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] line_hash;
  } in_item_t;

  typedef struct packed {
    logic [1:0] row_kind;
    logic [4:0] a_line;
    logic       a_present;
    logic [4:0] b_line;
    logic       b_present;
    logic       last_row;
    logic       rows_capped;
    logic       raw_dump_used;
    logic [6:0] added_count;
    logic [6:0] removed_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILL_RD, ST_FILL_WR, ST_BT_RD, ST_BT_DEC, ST_RAW, ST_EMIT_RD,
    ST_EMIT, ST_EMPTY
  } lcd_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // take the input beat
    logic fill_start;
    logic fill_step;   // write one table cell, advance
    logic bt_start;
    logic bt_step;     // push one backtrack row
    logic raw_start;
    logic raw_step;
    logic emit_start;
    logic emit_rd;
    logic out_load;
    logic out_empty;
  } lcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic both_empty;
    logic one_empty;
    logic fill_done;
    logic bt_done;
    logic raw_done;
    logic emit_last;
  } lcd_stat_t;
endpackage

// ===== src/lcd_ctrl.sv =====
module lcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2:0]        in_op,
  input  logic              force_raw,
  input  logic              out_busy,
  input  lcd_pkg::lcd_stat_t stat,
  output lcd_pkg::lcd_cmd_t  cmd,
  output logic              in_stall
);
  import lcd_pkg::*;
  lcd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == OP_COMPARE) begin
            if (stat.both_empty) state_next = ST_EMPTY;
            else if (stat.one_empty || force_raw) begin
              cmd.raw_start = 1'b1;
              state_next = ST_RAW;
            end else begin
              cmd.fill_start = 1'b1;
              state_next = ST_FILL_RD;
            end
          end
        end
      end
      ST_FILL_RD: state_next = ST_FILL_WR;
      ST_FILL_WR: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_done) begin
          cmd.bt_start = 1'b1;
          state_next = ST_BT_RD;
        end else state_next = ST_FILL_RD;
      end
      ST_BT_RD: state_next = ST_BT_DEC;
      ST_BT_DEC: begin
        cmd.bt_step = 1'b1;
        if (stat.bt_done) begin
          cmd.emit_start = 1'b1;
          state_next = ST_EMIT_RD;
        end else state_next = ST_BT_RD;
      end
      ST_RAW: begin
        cmd.raw_step = 1'b1;
        if (stat.raw_done) begin
          cmd.emit_start = 1'b1;
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EMPTY: begin
        if (!out_busy) begin
          cmd.out_empty = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== src/lcd_dpath.sv =====
module lcd_dpath #(
  parameter int MAX_LINES = lcd_pkg::MaxLinesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  lcd_pkg::in_item_t   in_item,
  input  logic [6:0]         row_limit,
  input  logic               force_raw,
  input  lcd_pkg::lcd_cmd_t   cmd,
  output lcd_pkg::lcd_stat_t  stat,
  output lcd_pkg::out_item_t  row_item
);
  import lcd_pkg::*;
  localparam int LW = $clog2(MAX_LINES + 1);      // length width
  localparam int IW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CELLS = (MAX_LINES + 1) * (MAX_LINES + 1);
  localparam int TW = $clog2(CELLS);
  localparam int SD = 2 * MAX_LINES;
  localparam int SW = $clog2(SD + 1);
  localparam int SAW = $clog2(SD);                 // stack address width
  localparam int EW = LW + LW + 2;                 // stack entry: kind, ai, bi

  logic [31:0] a_mem [MAX_LINES];
  logic [31:0] b_mem [MAX_LINES];
  logic [LW-1:0] lcs_mem [CELLS];
  logic [EW-1:0] stk_mem [SD];

  logic [LW-1:0] a_length, b_length;
  logic [LW-1:0] i, j;        // walk indices
  logic [TW-1:0] addr;        // cell (i, j)
  logic [SW-1:0] n;           // stack fill
  logic [SW-1:0] k, total, written;
  logic [31:0] ah, bh;
  logic [LW-1:0] c_diag, c_up, c_lf;
  logic raw_flag;
  logic [6:0] added, removed;
  logic [EW-1:0] stk_rd;
  logic [6:0] limit;

  // list loads
  always_ff @(posedge clk) begin
    if (rst) begin
      a_length <= '0;
      b_length <= '0;
    end else if (cmd.load) begin
      unique case (in_item.op)
        OP_APPEND_A: if (a_length < LW'(MAX_LINES)) a_length <= a_length + 1'b1;
        OP_APPEND_B: if (b_length < LW'(MAX_LINES)) b_length <= b_length + 1'b1;
        OP_CLEAR_A: a_length <= '0;
        OP_CLEAR_B: b_length <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_item.op == OP_APPEND_A && a_length < LW'(MAX_LINES))
      a_mem[a_length[IW-1:0]] <= in_item.line_hash;
    if (cmd.load && in_item.op == OP_APPEND_B && b_length < LW'(MAX_LINES))
      b_mem[b_length[IW-1:0]] <= in_item.line_hash;
  end

  logic [IW-1:0] ia, jb;
  assign ia = IW'(i - 1'b1);
  assign jb = IW'(j - 1'b1);
  logic [TW-1:0] w;
  assign w = TW'(b_length) + 1'b1;

  // hash and table reads (registered); the diagonal is the previous cell's up value
  always_ff @(posedge clk) begin
    ah <= a_mem[ia];
    bh <= b_mem[jb];
    c_up   <= lcs_mem[addr - w];
    c_lf   <= lcs_mem[addr - 1'b1];
    if (cmd.fill_step) c_diag <= c_up;
    stk_rd <= stk_mem[SAW'(total - 1'b1 - k)];
  end

  logic match;
  assign match = (ah == bh);
  logic [LW-1:0] cell_val;
  assign cell_val = match ? c_diag + 1'b1 : ((c_up >= c_lf) ? c_up : c_lf);

  // table write: row/col 0 cells are zero
  logic edge0;
  assign edge0 = (i == '0) || (j == '0);
  always_ff @(posedge clk) begin
    if (cmd.fill_step) lcs_mem[addr] <= edge0 ? '0 : cell_val;
  end

  // backtrack decision
  logic [1:0] bt_kind;
  always_comb begin
    priority if (i != '0 && j != '0 && match) bt_kind = KIND_SAME;
    else if (i == '0) bt_kind = KIND_BONLY;
    else if (j == '0) bt_kind = KIND_AONLY;
    else if (c_lf >= c_up) bt_kind = KIND_BONLY;
    else bt_kind = KIND_AONLY;
  end

  logic [1:0] raw_kind;
  assign raw_kind = (j != '0) ? KIND_BONLY : KIND_AONLY;

  logic push;
  logic [1:0] push_kind;
  assign push = cmd.bt_step || cmd.raw_step;
  assign push_kind = cmd.bt_step ? bt_kind : raw_kind;

  always_ff @(posedge clk) begin
    if (push && n < SW'(SD))
      stk_mem[n[SAW-1:0]] <= {push_kind,
                              (push_kind == KIND_BONLY) ? '0 : LW'(i - 1'b1),
                              (push_kind == KIND_AONLY) ? '0 : LW'(j - 1'b1)};
  end

  logic [LW-1:0] i_n, j_n;
  always_comb begin
    i_n = i;
    j_n = j;
    if (push_kind != KIND_BONLY) i_n = i - 1'b1;
    if (push_kind != KIND_AONLY) j_n = j - 1'b1;
  end

  assign limit = (row_limit == 7'd0) ? 7'd1 :
                 (row_limit > 7'(RowCap)) ? 7'(RowCap) : row_limit;

  // walk control
  always_ff @(posedge clk) begin
    if (cmd.fill_start) begin
      i <= '0;
      j <= '0;
      addr <= '0;
    end else if (cmd.bt_start || cmd.raw_start) begin
      i <= a_length;
      j <= b_length;
      addr <= TW'(a_length) * w + TW'(b_length);
      n <= '0;
      raw_flag <= cmd.raw_start && force_raw && a_length != '0 && b_length != '0;
    end else if (cmd.fill_step) begin
      addr <= addr + 1'b1;
      if (j == b_length) begin
        j <= '0;
        i <= i + 1'b1;
      end else j <= j + 1'b1;
    end else if (push) begin
      i <= i_n;
      j <= j_n;
      addr <= addr - ((push_kind != KIND_BONLY) ? w : '0)
                   - ((push_kind != KIND_AONLY) ? TW'(1) : '0);
      n <= n + 1'b1;
    end
    if (cmd.emit_start) begin
      k <= '0;
      total <= n + 1'b1;
      written <= (SW'(n) + 1'b1 > SW'(limit)) ? SW'(limit) : n + 1'b1;
      added <= '0;
      removed <= '0;
    end else if (cmd.out_load) begin
      k <= k + 1'b1;
      if (stk_rd[EW-1-:2] == KIND_AONLY) removed <= removed + 1'b1;
      if (stk_rd[EW-1-:2] == KIND_BONLY) added <= added + 1'b1;
    end
  end

  logic fill_last;
  assign fill_last = (i == a_length) && (j == b_length);
  logic after_push_zero;
  assign after_push_zero = (i_n == '0) && (j_n == '0);

  assign stat.both_empty = (a_length == '0) && (b_length == '0);
  assign stat.one_empty  = (a_length == '0) || (b_length == '0);
  assign stat.fill_done  = fill_last;
  assign stat.bt_done    = after_push_zero;
  assign stat.raw_done   = after_push_zero;
  assign stat.emit_last  = (k + 1'b1 == written);

  // row assembly
  logic [1:0] rk;
  logic last;
  assign rk = stk_rd[EW-1-:2];
  assign last = stat.emit_last;
  always_comb begin
    row_item = '0;
    if (cmd.out_empty) begin
      row_item.row_kind = KIND_NONE;
      row_item.last_row = 1'b1;
    end else begin
      row_item.row_kind = rk;
      row_item.a_present = (rk != KIND_BONLY);
      row_item.b_present = (rk != KIND_AONLY);
      row_item.a_line = row_item.a_present ? 5'(stk_rd[LW+LW-1:LW]) : '0;
      row_item.b_line = row_item.b_present ? 5'(stk_rd[LW-1:0]) : '0;
      row_item.raw_dump_used = raw_flag;
      if (last) begin
        row_item.last_row = 1'b1;
        row_item.rows_capped = (total > written);
        row_item.added_count = added + ((rk == KIND_BONLY) ? 7'd1 : 7'd0);
        row_item.removed_count = removed + ((rk == KIND_AONLY) ? 7'd1 : 7'd0);
      end
    end
  end
endmodule

// ===== src/lcs_line_diff_unit.sv =====
// Load, clear and unused ops: one beat per cycle, no result. Compare: read and
// write per table cell over (A+1)*(B+1) cells, read and decide per backtrack row,
// then read and output per emitted row plus any output stall; raw dump pushes 1
// row per cycle. Empty compare: its row is loaded when the output is free. Input
// stalls until the last row of a compare is in the output register. Reset (rst,
// synchronous) empties both lists, sets the row limit to 64, turns raw dump off.
module lcs_line_diff_unit #(
  parameter int MAX_LINES = lcd_pkg::MaxLinesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lcd_pkg::in_item_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lcd_pkg::out_item_t  out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);
  import lcd_pkg::*;
  `include "lcs_line_diff_unit_assert.svh"

  logic [6:0] row_limit;
  logic force_raw;
  lcd_cmd_t cmd;
  lcd_stat_t stat;
  out_item_t row_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit <= 7'd64;
      force_raw <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_LIMIT: row_limit <= cfg_data;
        CFG_FORCE_RAW: force_raw <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic out_busy;
  assign out_busy = out_valid && out_stall;

  lcd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_op(in_data.op), .force_raw, .out_busy,
    .stat, .cmd, .in_stall
  );

  lcd_dpath #(.MAX_LINES(MAX_LINES)) u_dpath (
    .clk, .rst, .in_item(in_data), .row_limit, .force_raw, .cmd, .stat, .row_item
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load || cmd.out_empty) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load || cmd.out_empty) out_data <= row_item;
  end

  logic same_row;
  assign same_row = out_valid && (out_data.row_kind == KIND_SAME);

  `LCD_ASSERT_IMP(a_no_overwrite, out_busy, !(cmd.out_load || cmd.out_empty))
  `LCD_ASSERT_NXT(a_empty_last, cmd.out_empty, out_valid && out_data.last_row)
  `LCD_ASSERT_IMP(a_kind_present, same_row, out_data.a_present && out_data.b_present)
endmodule
